// ===== src/pba_pkg.sv =====
package pba_pkg;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 13;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // parameter defaults
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_MAX_PAGES  = 4096;

    // region size after reset
    localparam int RESET_REGION_PAGES = 4096;

    // bitmap byte with every page used
    localparam logic [7:0] BYTE_ALL_USED = 8'hff;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // request kinds
    localparam t_kind KIND_ALLOC   = 2'd0;
    localparam t_kind KIND_FREE    = 2'd1;
    localparam t_kind KIND_RESERVE = 2'd2;
    localparam t_kind KIND_RELEASE = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx CFG_REGION_BASE  = 1'b0;
    localparam t_cfg_idx CFG_REGION_PAGES = 1'b1;

endpackage

// ===== src/pba_ram.sv =====
module pba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pba_range.sv =====
module pba_range #(
    parameter int PAGE_SHIFT = 12,
    parameter int IDX_W      = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [pba_pkg::ADDR_W:0]   i_start_addr,
    input  logic [pba_pkg::ADDR_W:0]   i_end_addr,
    input  logic [pba_pkg::ADDR_W-1:0] i_region_base,
    input  logic [IDX_W-1:0]       i_active_pages,
    output logic                   o_done,
    output logic [IDX_W-1:0]       o_lo,
    output logic [IDX_W-1:0]       o_hi
);
    import pba_pkg::*;

    localparam int ALW = ADDR_W + 2;
    localparam logic [ALW-1:0] PG_MASK = (ALW'(1) << PAGE_SHIFT) - ALW'(1);

    logic           r_stage_a;
    logic [ALW-1:0] r_alg_lo;
    logic [ALW-1:0] r_alg_hi;
    logic           r_done;
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;

    // first page whose start is at or above an aligned address, clamped
    function automatic logic [IDX_W-1:0] page_index(
        input logic [ALW-1:0]    aligned,
        input logic [ADDR_W-1:0] base,
        input logic [IDX_W-1:0]  n
    );
        logic [ALW-1:0] sum;
        logic [ALW-1:0] q;
        logic [IDX_W-1:0] idx;
        sum = aligned - ALW'(base) + PG_MASK;
        q   = sum >> PAGE_SHIFT;
        if (aligned <= ALW'(base)) begin
            idx = '0;
        end else if (q > ALW'(n)) begin
            idx = n;
        end else begin
            idx = IDX_W'(q);
        end
        return idx;
    endfunction

    // stage a: round both ends up to a page boundary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_a <= 1'b0;
        end else begin
            r_stage_a <= i_load;
        end
        if (i_load) begin
            r_alg_lo <= (ALW'(i_start_addr) + PG_MASK) & ~PG_MASK;
            r_alg_hi <= (ALW'(i_end_addr) + PG_MASK) & ~PG_MASK;
        end
    end

    // stage b: convert to page indexes inside the region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_stage_a;
        end
        if (r_stage_a) begin
            r_lo <= page_index(r_alg_lo, i_region_base, i_active_pages);
            r_hi <= page_index(r_alg_hi, i_region_base, i_active_pages);
        end
    end

    assign o_done = r_done;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;

endmodule

// ===== src/page_bitmap_allocator.sv =====
// First-fit bitmap page allocator, one used bit per page.
// Request channel: kind, start_addr and end_addr are taken at a clock edge
// with i_start high and o_busy low. Each request not cut short by a
// region_pages write gives exactly one result, shown for one cycle with
// o_valid high; the receiver cannot stall it. Kinds: allocate the lowest
// free page, free one page, reserve a range, release a range. Counts in
// the result are those after the request. Configuration: i_cfg_valid /
// o_cfg_ready with i_cfg_index and i_cfg_data; ready is always high.
// Index 0 is region_base, index 1 is region_pages; writing region_pages
// marks every page used again. Storage: the bitmap lives in a RAM of one
// byte per eight pages, read one byte a cycle through a registered read
// port. Allocate reads bytes from the first until one has a free page, at
// most those that cover the region's pages. A range request first turns
// its ends into page indexes in stages a and b of pba_range, then does a
// read-modify-write of each byte it touches. Reset and every region_pages
// write starts a clearing pass over all ceil(MAX_PAGES / 8) bytes (512 by
// default) that sets the bitmap to all ones; o_busy is high during it.
module page_bitmap_allocator #(
    parameter int PAGE_SHIFT = pba_pkg::DEF_PAGE_SHIFT,
    parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  pba_pkg::t_kind            i_kind,
    input  logic [pba_pkg::ADDR_W-1:0]    i_start_addr,
    input  logic [pba_pkg::ADDR_W-1:0]    i_end_addr,
    output logic                      o_valid,
    output logic [pba_pkg::ADDR_W-1:0]    o_page_addr,
    output logic                      o_found,
    output logic [pba_pkg::CNT_W-1:0]     o_used_count,
    output logic [pba_pkg::CNT_W-1:0]     o_free_count,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  pba_pkg::t_cfg_idx         i_cfg_index,
    input  logic [pba_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pba_pkg::*;

    localparam int MAP_DEPTH = (MAX_PAGES + 7) / 8;
    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int IW = $clog2(MAX_PAGES + 1);
    localparam int RESET_ACTIVE_I =
        (RESET_REGION_PAGES > MAX_PAGES) ? MAX_PAGES : RESET_REGION_PAGES;
    localparam logic [IW-1:0] RESET_ACTIVE = IW'(RESET_ACTIVE_I);
    localparam logic [ADDR_W:0] PAGE_BYTES = (ADDR_W + 1)'(1) << PAGE_SHIFT;

    // controller states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_set, n_set;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_addr, n_pend_addr;
    logic [AW-1:0]     r_last, n_last;
    logic [IW-1:0]     r_lo, n_lo;
    logic [IW-1:0]     r_hi, n_hi;
    logic [IW-1:0]     r_used, n_used;
    logic [IW-1:0]     r_free, n_free;
    logic [IW-1:0]     r_active, n_active;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic              r_out_found, n_out_found;
    logic [CNT_W-1:0]  r_out_used, n_out_used;
    logic [CNT_W-1:0]  r_out_free, n_out_free;

    logic              accept;
    logic              cfg_wr;
    logic [CNT_W-1:0]  cfg_pages;
    logic [IW-1:0]     cfg_active;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic              rng_done;
    logic [IW-1:0]     rng_lo;
    logic [IW-1:0]     rng_hi;
    logic [ADDR_W:0]   rng_start;
    logic [ADDR_W:0]   rng_end;

    logic [7:0]        walk_mask;
    logic [7:0]        walk_flips;
    logic [7:0]        walk_byte;
    logic [3:0]        walk_cnt;
    logic [2:0]        zero_pos;
    logic [7:0]        zero_mask;
    logic [ADDR_W-1:0] alloc_addr;

    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_pages   = i_cfg_data[CNT_W-1:0];
    assign cfg_active  = (32'(cfg_pages) > 32'(MAX_PAGES)) ? IW'(MAX_PAGES) : IW'(cfg_pages);

    // bitmap store
    pba_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH),
        .ADDR_W(AW)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_rd_addr),
        .o_rdata(ram_rdata)
    );

    // range ends to page indexes; free covers exactly one page
    assign rng_start = {1'b0, i_start_addr};
    assign rng_end   = (i_kind == KIND_FREE) ? rng_start + PAGE_BYTES : {1'b0, i_end_addr};

    pba_range #(
        .PAGE_SHIFT(PAGE_SHIFT),
        .IDX_W     (IW)
    ) u_range (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept && (i_kind != KIND_ALLOC)),
        .i_start_addr  (rng_start),
        .i_end_addr    (rng_end),
        .i_region_base (r_base),
        .i_active_pages(r_active),
        .o_done        (rng_done),
        .o_lo          (rng_lo),
        .o_hi          (rng_hi)
    );

    // pages of the pending byte that lie in the range
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            walk_mask[j] = (32'({r_pend_addr, 3'(j)}) >= 32'(r_lo)) &&
                           (32'({r_pend_addr, 3'(j)}) < 32'(r_hi));
        end
        walk_flips = r_set ? (walk_mask & ~ram_rdata) : (walk_mask & ram_rdata);
        walk_byte  = r_set ? (ram_rdata | walk_mask) : (ram_rdata & ~walk_mask);
        walk_cnt   = 4'($countones(walk_flips));
    end

    // lowest free page in the pending byte
    always_comb begin
        zero_pos = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!ram_rdata[j]) begin
                zero_pos = 3'(j);
            end
        end
        zero_mask  = 8'(1) << zero_pos;
        alloc_addr = r_base + (ADDR_W'({r_pend_addr, zero_pos}) << PAGE_SHIFT);
    end

    // controller
    always_comb begin
        n_state     = r_state;
        n_set       = r_set;
        n_rd_addr   = r_rd_addr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_last      = r_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_used      = r_used;
        n_free      = r_free;
        n_active    = r_active;
        n_base      = r_base;
        n_clr_addr  = r_clr_addr;
        n_out_valid = 1'b0;
        n_out_addr  = r_out_addr;
        n_out_found = r_out_found;
        n_out_used  = r_out_used;
        n_out_free  = r_out_free;
        ram_we      = 1'b0;
        ram_waddr   = r_pend_addr;
        ram_wdata   = walk_byte;

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = BYTE_ALL_USED;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAP_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_set  = (i_kind == KIND_RESERVE);
                    n_pend = 1'b0;
                    if (i_kind != KIND_ALLOC) begin
                        n_state = ST_CALC;
                    end else if (r_active == '0) begin
                        n_out_valid = 1'b1;
                        n_out_addr  = '0;
                        n_out_found = 1'b0;
                        n_out_used  = CNT_W'(r_used);
                        n_out_free  = CNT_W'(r_free);
                    end else begin
                        n_rd_addr = '0;
                        n_last    = AW'((r_active - IW'(1)) >> 3);
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_CALC: begin
                if (rng_done) begin
                    if (rng_lo >= rng_hi) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        n_out_addr  = '0;
                        n_out_found = 1'b0;
                        n_out_used  = CNT_W'(r_used);
                        n_out_free  = CNT_W'(r_free);
                    end else begin
                        n_lo      = rng_lo;
                        n_hi      = rng_hi;
                        n_rd_addr = AW'(rng_lo >> 3);
                        n_last    = AW'((rng_hi - IW'(1)) >> 3);
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // read the next byte while the previous one is written back
                n_rd_addr   = r_rd_addr + AW'(1);
                n_pend      = 1'b1;
                n_pend_addr = r_rd_addr;
                if (r_pend) begin
                    ram_we = 1'b1;
                    if (r_set) begin
                        n_used = r_used + IW'(walk_cnt);
                        n_free = r_free - IW'(walk_cnt);
                    end else begin
                        n_used = r_used - IW'(walk_cnt);
                        n_free = r_free + IW'(walk_cnt);
                    end
                    if (r_pend_addr == r_last) begin
                        n_state     = ST_IDLE;
                        n_pend      = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_addr  = '0;
                        n_out_found = 1'b0;
                        n_out_used  = CNT_W'(n_used);
                        n_out_free  = CNT_W'(n_free);
                    end
                end
            end
            ST_SCAN: begin
                n_rd_addr   = r_rd_addr + AW'(1);
                n_pend      = 1'b1;
                n_pend_addr = r_rd_addr;
                if (r_pend) begin
                    if (ram_rdata != BYTE_ALL_USED) begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata | zero_mask;
                        n_used      = r_used + IW'(1);
                        n_free      = (r_free != '0) ? r_free - IW'(1) : r_free;
                        n_state     = ST_IDLE;
                        n_pend      = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_addr  = alloc_addr;
                        n_out_found = 1'b1;
                        n_out_used  = CNT_W'(n_used);
                        n_out_free  = CNT_W'(n_free);
                    end else if (r_pend_addr == r_last) begin
                        n_state     = ST_IDLE;
                        n_pend      = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_addr  = '0;
                        n_out_found = 1'b0;
                        n_out_used  = CNT_W'(r_used);
                        n_out_free  = CNT_W'(r_free);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // configuration beats
        if (cfg_wr) begin
            if (i_cfg_index == CFG_REGION_BASE) begin
                n_base = i_cfg_data[ADDR_W-1:0];
            end else begin
                n_active   = cfg_active;
                n_used     = cfg_active;
                n_free     = '0;
                n_clr_addr = '0;
                n_pend     = 1'b0;
                n_state    = ST_CLEAR;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_used      <= RESET_ACTIVE;
            r_free      <= '0;
            r_active    <= RESET_ACTIVE;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_used      <= n_used;
            r_free      <= n_free;
            r_active    <= n_active;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_set       <= n_set;
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= n_pend_addr;
        r_last      <= n_last;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_out_addr  <= n_out_addr;
        r_out_found <= n_out_found;
        r_out_used  <= n_out_used;
        r_out_free  <= n_out_free;
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_page_addr  = r_out_addr;
    assign o_found      = r_out_found;
    assign o_used_count = r_out_used;
    assign o_free_count = r_out_free;

endmodule
